// ===== src/cell_voltage_protection_watch_macros.svh =====
// assertion macros shared by the rtl files
`ifndef CELL_VOLTAGE_PROTECTION_WATCH_MACROS_SVH
`define CELL_VOLTAGE_PROTECTION_WATCH_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CVPW_ASSERT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CVPW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CVPW_ASSERT(name, clk, rst_n, ante, cons)
`define CVPW_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/cvpw_pkg.sv =====
package cvpw_pkg;

    typedef struct packed {
        logic [12:0] cell_voltage_mv;
        logic        last_cell;
        logic [31:0] now_ms;
        logic [15:0] hard_under_flags;
        logic [15:0] hard_over_flags;
        logic [17:0] pack_voltage_mv;
    } cell_in_t;

    typedef struct packed {
        logic        low_current_ok;
        logic        high_current_ok;
        logic        charge_ok;
        logic [1:0]  pack_state;
        logic [12:0] highest_cell_mv;
        logic [13:0] lowest_cell_mv;
        logic        switch_update;
    } result_out_t;

    typedef struct packed {
        logic [4:0]  cell_count;
        logic [12:0] low_current_under_mv;
        logic [12:0] high_current_under_mv;
        logic [12:0] soft_over_mv;
        logic [12:0] discharge_hysteresis_mv;
        logic [12:0] charge_hysteresis_mv;
        logic [12:0] hard_over_mv;
        logic [7:0]  max_hard_errors;
    } cfg_t;

    // limits derived from the configuration
    typedef struct packed {
        logic [17:0] pack_limit_mv;
        logic [13:0] lc_recover_mv;
        logic [13:0] hc_recover_mv;
        logic [12:0] chg_recover_mv;
        logic        chg_recover_en;
    } limits_t;

    typedef enum logic [2:0] {
        REG_CELL_COUNT    = 3'd0,
        REG_LC_UNDER      = 3'd1,
        REG_HC_UNDER      = 3'd2,
        REG_SOFT_OVER     = 3'd3,
        REG_DISCHARGE_HYS = 3'd4,
        REG_CHARGE_HYS    = 3'd5,
        REG_HARD_OVER     = 3'd6,
        REG_MAX_HARD_ERR  = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_SOFT   = 2'd1,
        ST_HARD   = 2'd2
    } pack_state_t;

    localparam logic [13:0] LOW_START_MV   = 14'd10000;
    localparam logic [7:0]  HARD_COUNT_MAX = 8'd255;

    localparam cfg_t CFG_RESET = '{
        cell_count:              5'd12,
        low_current_under_mv:    13'd3000,
        high_current_under_mv:   13'd2900,
        soft_over_mv:            13'd4150,
        discharge_hysteresis_mv: 13'd250,
        charge_hysteresis_mv:    13'd250,
        hard_over_mv:            13'd4200,
        max_hard_errors:         8'd5
    };

    localparam limits_t LIMITS_RESET = '{
        pack_limit_mv:  18'd50400,
        lc_recover_mv:  14'd3250,
        hc_recover_mv:  14'd3150,
        chg_recover_mv: 13'd3900,
        chg_recover_en: 1'b1
    };

endpackage

// ===== src/cvpw_cfg.sv =====
module cvpw_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [12:0]          cfg_data,
    output cvpw_pkg::cfg_t       cfg,
    output cvpw_pkg::limits_t    limits
);

    cvpw_pkg::cfg_t    cfg_reg;
    cvpw_pkg::cfg_t    cfg_next;
    cvpw_pkg::limits_t lim_reg;
    cvpw_pkg::limits_t lim_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cvpw_pkg::REG_CELL_COUNT:    cfg_next.cell_count = cfg_data[4:0];
                cvpw_pkg::REG_LC_UNDER:      cfg_next.low_current_under_mv = cfg_data;
                cvpw_pkg::REG_HC_UNDER:      cfg_next.high_current_under_mv = cfg_data;
                cvpw_pkg::REG_SOFT_OVER:     cfg_next.soft_over_mv = cfg_data;
                cvpw_pkg::REG_DISCHARGE_HYS: cfg_next.discharge_hysteresis_mv = cfg_data;
                cvpw_pkg::REG_CHARGE_HYS:    cfg_next.charge_hysteresis_mv = cfg_data;
                cvpw_pkg::REG_HARD_OVER:     cfg_next.hard_over_mv = cfg_data;
                cvpw_pkg::REG_MAX_HARD_ERR:  cfg_next.max_hard_errors = cfg_data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // limits are registered from the config registers and follow them in the next cycle
    always_comb
    begin
        lim_next.pack_limit_mv  = 18'(cfg_reg.cell_count) * 18'(cfg_reg.hard_over_mv);
        lim_next.lc_recover_mv  = 14'(cfg_reg.low_current_under_mv)
                                + 14'(cfg_reg.discharge_hysteresis_mv);
        lim_next.hc_recover_mv  = 14'(cfg_reg.high_current_under_mv)
                                + 14'(cfg_reg.discharge_hysteresis_mv);
        lim_next.chg_recover_mv = cfg_reg.soft_over_mv - cfg_reg.charge_hysteresis_mv;
        lim_next.chg_recover_en = cfg_reg.charge_hysteresis_mv <= cfg_reg.soft_over_mv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= cvpw_pkg::CFG_RESET;
            lim_reg <= cvpw_pkg::LIMITS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
            lim_reg <= lim_next;
        end
    end

    assign cfg    = cfg_reg;
    assign limits = lim_reg;

endmodule

// ===== src/cvpw_core.sv =====
`include "cell_voltage_protection_watch_macros.svh"

module cvpw_core #(
    parameter int unsigned DISCHARGE_RETRY_MS = 5000,
    parameter int unsigned CHARGE_RETRY_MS    = 30000
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   update,
    input  cvpw_pkg::cell_in_t     item,
    input  cvpw_pkg::cfg_t         cfg,
    input  cvpw_pkg::limits_t      limits,
    output cvpw_pkg::result_out_t  res
);

    localparam logic [31:0] DIS_TIMEOUT = 32'(DISCHARGE_RETRY_MS);
    localparam logic [31:0] CHG_TIMEOUT = 32'(CHARGE_RETRY_MS);

    logic [12:0] run_high_reg, run_high_next;
    logic [13:0] run_low_reg, run_low_next;
    logic        lc_allowed_reg, lc_allowed_next;
    logic        hc_allowed_reg, hc_allowed_next;
    logic        chg_allowed_reg, chg_allowed_next;
    logic [31:0] lc_stamp_reg, lc_stamp_next;
    logic [31:0] hc_stamp_reg, hc_stamp_next;
    logic [31:0] chg_stamp_reg, chg_stamp_next;
    cvpw_pkg::pack_state_t state_reg, state_next;
    logic [7:0]  err_count_reg, err_count_next;
    logic        rep_chg_reg, rep_chg_next;
    logic        rep_lc_reg, rep_lc_next;

    logic [12:0] hi_new;
    logic [13:0] lo_new;
    logic [31:0] now;
    logic        soft_active;
    logic        lc_hit, hc_hit, chg_hit;
    logic        lc_fire, hc_fire, chg_fire;
    logic [31:0] lc_base, hc_base, chg_base;
    logic        lc_soft, hc_soft, chg_soft;
    logic [31:0] lc_stamp_soft, hc_stamp_soft, chg_stamp_soft;
    cvpw_pkg::pack_state_t state_soft;
    logic        hard_err;
    logic        lc_final, chg_final;
    logic        changed;

    always_comb
    begin
        now    = item.now_ms;
        hi_new = (item.cell_voltage_mv > run_high_reg) ? item.cell_voltage_mv : run_high_reg;
        lo_new = ({1'b0, item.cell_voltage_mv} < run_low_reg)
               ? {1'b0, item.cell_voltage_mv} : run_low_reg;

        soft_active = state_reg != cvpw_pkg::ST_HARD;

        // soft limit hits
        lc_hit  = lo_new <= {1'b0, cfg.low_current_under_mv};
        hc_hit  = lo_new <= {1'b0, cfg.high_current_under_mv};
        chg_hit = hi_new >= cfg.soft_over_mv;

        // retry timers see the stamp after any hit
        lc_base  = lc_hit ? now : lc_stamp_reg;
        hc_base  = hc_hit ? now : hc_stamp_reg;
        chg_base = chg_hit ? now : chg_stamp_reg;

        lc_fire  = (lo_new >= limits.lc_recover_mv) && ((now - lc_base) >= DIS_TIMEOUT);
        hc_fire  = (lo_new >= limits.hc_recover_mv) && ((now - hc_base) >= DIS_TIMEOUT);
        chg_fire = limits.chg_recover_en && (hi_new <= limits.chg_recover_mv)
                && ((now - chg_base) >= CHG_TIMEOUT);

        if (soft_active)
        begin
            lc_soft  = lc_fire  | (~lc_hit  & lc_allowed_reg);
            hc_soft  = hc_fire  | (~hc_hit  & hc_allowed_reg);
            chg_soft = chg_fire | (~chg_hit & chg_allowed_reg);
            lc_stamp_soft  = (lc_hit  || lc_fire)  ? now : lc_stamp_reg;
            hc_stamp_soft  = (hc_hit  || hc_fire)  ? now : hc_stamp_reg;
            chg_stamp_soft = (chg_hit || chg_fire) ? now : chg_stamp_reg;
            state_soft = (chg_soft && lc_soft) ? cvpw_pkg::ST_NORMAL : cvpw_pkg::ST_SOFT;
        end
        else
        begin
            lc_soft  = lc_allowed_reg;
            hc_soft  = hc_allowed_reg;
            chg_soft = chg_allowed_reg;
            lc_stamp_soft  = lc_stamp_reg;
            hc_stamp_soft  = hc_stamp_reg;
            chg_stamp_soft = chg_stamp_reg;
            state_soft = state_reg;
        end

        // hard errors
        hard_err = (|item.hard_under_flags) || (|item.hard_over_flags)
                || (item.pack_voltage_mv > limits.pack_limit_mv);

        lc_final  = lc_soft & ~hard_err;
        chg_final = chg_soft & ~hard_err;
        changed   = (rep_chg_reg != chg_final) || (rep_lc_reg != lc_final);

        res.low_current_ok  = lc_final;
        res.high_current_ok = hc_soft;
        res.charge_ok       = chg_final;
        res.pack_state      = (hard_err && (err_count_reg > cfg.max_hard_errors))
                            ? cvpw_pkg::ST_HARD : state_soft;
        res.highest_cell_mv = hi_new;
        res.lowest_cell_mv  = lo_new;
        res.switch_update   = changed;
    end

    always_comb
    begin
        run_high_next    = run_high_reg;
        run_low_next     = run_low_reg;
        lc_allowed_next  = lc_allowed_reg;
        hc_allowed_next  = hc_allowed_reg;
        chg_allowed_next = chg_allowed_reg;
        lc_stamp_next    = lc_stamp_reg;
        hc_stamp_next    = hc_stamp_reg;
        chg_stamp_next   = chg_stamp_reg;
        state_next       = state_reg;
        err_count_next   = err_count_reg;
        rep_chg_next     = rep_chg_reg;
        rep_lc_next      = rep_lc_reg;
        if (update)
        begin
            if (item.last_cell)
            begin
                // close the round
                run_high_next    = '0;
                run_low_next     = cvpw_pkg::LOW_START_MV;
                lc_allowed_next  = lc_final;
                hc_allowed_next  = hc_soft;
                chg_allowed_next = chg_final;
                lc_stamp_next    = lc_stamp_soft;
                hc_stamp_next    = hc_stamp_soft;
                chg_stamp_next   = chg_stamp_soft;
                state_next       = cvpw_pkg::pack_state_t'(res.pack_state);
                if (hard_err)
                begin
                    if (err_count_reg != cvpw_pkg::HARD_COUNT_MAX)
                    begin
                        err_count_next = err_count_reg + 8'd1;
                    end
                end
                else
                begin
                    err_count_next = '0;
                end
                rep_chg_next = chg_final;
                rep_lc_next  = lc_final;
            end
            else
            begin
                run_high_next = hi_new;
                run_low_next  = lo_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_high_reg    <= '0;
            run_low_reg     <= cvpw_pkg::LOW_START_MV;
            lc_allowed_reg  <= 1'b1;
            hc_allowed_reg  <= 1'b1;
            chg_allowed_reg <= 1'b1;
            lc_stamp_reg    <= '0;
            hc_stamp_reg    <= '0;
            chg_stamp_reg   <= '0;
            state_reg       <= cvpw_pkg::ST_NORMAL;
            err_count_reg   <= '0;
            rep_chg_reg     <= 1'b0;
            rep_lc_reg      <= 1'b0;
        end
        else
        begin
            run_high_reg    <= run_high_next;
            run_low_reg     <= run_low_next;
            lc_allowed_reg  <= lc_allowed_next;
            hc_allowed_reg  <= hc_allowed_next;
            chg_allowed_reg <= chg_allowed_next;
            lc_stamp_reg    <= lc_stamp_next;
            hc_stamp_reg    <= hc_stamp_next;
            chg_stamp_reg   <= chg_stamp_next;
            state_reg       <= state_next;
            err_count_reg   <= err_count_next;
            rep_chg_reg     <= rep_chg_next;
            rep_lc_reg      <= rep_lc_next;
        end
    end

    `CVPW_ASSERT_NEXT(a_hard_sticky, clk, rst_n, state_reg == cvpw_pkg::ST_HARD, state_reg == cvpw_pkg::ST_HARD)
    `CVPW_ASSERT_NEXT(a_hard_blocks, clk, rst_n, update && item.last_cell && hard_err, !lc_allowed_reg && !chg_allowed_reg)
    `CVPW_ASSERT_NEXT(a_round_restart, clk, rst_n, update && item.last_cell, run_high_reg == 13'd0 && run_low_reg == cvpw_pkg::LOW_START_MV)

endmodule

// ===== src/cell_voltage_protection_watch.sv =====
// channel  dir  handshake                    payload
// cell     in   cell_valid / cell_stall      cell_data (cvpw_pkg::cell_in_t)
// result   out  result_valid / result_stall  result_data (cvpw_pkg::result_out_t)
// cfg      in   cfg_we                       cfg_index, cfg_data
//
// one cell per cycle unless stalled; each cell passes through the input register
// the result of a round is valid the cycle after its last cell leaves that register
// reset restores register defaults and clears running extremes, flags and counters
// a held result stalls the input only while the waiting cell closes a round
`include "cell_voltage_protection_watch_macros.svh"

module cell_voltage_protection_watch #(
    parameter int unsigned DISCHARGE_RETRY_MS = 5000,
    parameter int unsigned CHARGE_RETRY_MS    = 30000
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cell_valid,
    output logic                   cell_stall,
    input  cvpw_pkg::cell_in_t     cell_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output cvpw_pkg::result_out_t  result_data,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [12:0]            cfg_data
);

    cvpw_pkg::cfg_t        cfg;
    cvpw_pkg::limits_t     limits;
    cvpw_pkg::result_out_t res;

    cvpw_pkg::cell_in_t    s1_reg, s1_next;
    logic                  s1_valid_reg, s1_valid_next;
    cvpw_pkg::result_out_t out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic out_free;
    logic s1_go;
    logic accept;

    cvpw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .limits    (limits)
    );

    cvpw_core #(
        .DISCHARGE_RETRY_MS (DISCHARGE_RETRY_MS),
        .CHARGE_RETRY_MS    (CHARGE_RETRY_MS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (s1_go),
        .item   (s1_reg),
        .cfg    (cfg),
        .limits (limits),
        .res    (res)
    );

    always_comb
    begin
        out_free   = !out_valid_reg || !result_stall;
        // cells that do not close a round never wait on the output
        s1_go      = s1_valid_reg && (!s1_reg.last_cell || out_free);
        cell_stall = s1_valid_reg && !s1_go;
        accept     = cell_valid && !cell_stall;

        s1_next       = accept ? cell_data : s1_reg;
        s1_valid_next = accept || (s1_valid_reg && !s1_go);

        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (s1_go && s1_reg.last_cell)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    `CVPW_ASSERT(a_stall_cause, clk, rst_n, cell_stall, s1_valid_reg && s1_reg.last_cell && out_valid_reg && result_stall)

endmodule
